// ----- rtl/aid_pkg.sv -----
package aid_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DevW    = 19;
  localparam int unsigned CfgW    = 19;
  localparam int unsigned NumAxes = 3;

  localparam logic [DevW-1:0] DevMax = '1;
  localparam logic [CfgW-1:0] ThresholdReset = CfgW'(2560);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } aid_axis_e;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_ENABLE    = 1'b1
  } aid_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic signed [SampleW-1:0] sample_z;
  } aid_in_t;

  typedef struct packed {
    logic            warming;
    logic            impact;
    logic [DevW-1:0] peak_deviation;
    aid_axis_e       peak_axis;
  } aid_out_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic warming;
  } aid_lane_ctl_t;

endpackage

// ----- rtl/accel_impact_detector.sv -----
// output: a result is registered and presented in the cycle after its sample request is taken
// throughput: one sample per cycle; the output register is refilled in the
// same cycle it is drained, so requests stall only while a result waits
// reset: window fill count cleared, last axis set to none, threshold 2560,
// detection enabled; window contents are not cleared
module accel_impact_detector import aid_pkg::*; #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  aid_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output aid_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  aid_reg_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] threshold_q;
  logic            enable_q;
  logic            out_valid_q, out_valid_d;
  aid_out_t        out_q;
  logic            step;
  aid_lane_ctl_t   ctl;
  aid_out_t        res;
  logic [DevW-1:0] dev [NumAxes];
  logic [SampleW-1:0] lane_sample [NumAxes];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o && enable_q;

  assign lane_sample[0] = in_data_i.sample_x;
  assign lane_sample[1] = in_data_i.sample_y;
  assign lane_sample[2] = in_data_i.sample_z;

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    aid_lane #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (lane_sample[a]),
      .ctl_i    (ctl),
      .dev_o    (dev[a])
    );
  end

  aid_merge #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .threshold_i (threshold_q),
    .dev_i       (dev),
    .ctl_o       (ctl),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      enable_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: threshold_q <= cfg_data_i;
        REG_ENABLE:    enable_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/aid_lane.sv -----
module aid_lane import aid_pkg::*; #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SampleW-1:0]  sample_i,
  input  aid_lane_ctl_t       ctl_i,
  output logic [DevW-1:0]     dev_o
);

  localparam int unsigned SumW  = SAMPLE_BITS + $clog2(WINDOW_LEN) + 1;
  localparam int unsigned DiffW = SumW + 1;
  localparam int unsigned CmpW  = (DiffW > DevW) ? DiffW : DevW;

  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [SAMPLE_BITS-1:0] win_q [WINDOW_LEN];
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic signed [SumW-1:0]        oldest;
  logic signed [DiffW-1:0]       s_ext, scaled, diff;
  logic        [DiffW-1:0]       mag;

  assign s = sample_i[SAMPLE_BITS-1:0];

  // deviation of the new sample from the window mean, times the window length
  assign s_ext  = DiffW'(s);
  assign scaled = s_ext * $signed(DiffW'(WINDOW_LEN));
  assign diff   = scaled - DiffW'(sum_q);
  assign mag    = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

  always_comb begin
    if (CmpW'(mag) > CmpW'(DevMax)) begin
      dev_o = DevMax;
    end else begin
      dev_o = DevW'(mag);
    end
  end

  // running window sum, oldest entry drops out once the window is full
  assign oldest = ctl_i.warming ? '0 : SumW'(win_q[0]);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clear) begin
      sum_d = '0;
    end else if (ctl_i.shift) begin
      sum_d = sum_q + SumW'(s) - oldest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_LEN-1] <= s;
    end
  end

endmodule

// ----- rtl/aid_merge.sv -----
module aid_merge import aid_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CfgW-1:0]  threshold_i,
  input  logic [DevW-1:0]  dev_i [NumAxes],
  output aid_lane_ctl_t    ctl_o,
  output aid_out_t         res_o
);

  localparam int unsigned FillW = $clog2(WINDOW_LEN + 1);

  logic [FillW-1:0] fill_q, fill_d;
  aid_axis_e        axis_q, axis_d;
  aid_axis_e        pick_axis;
  logic [DevW-1:0]  peak;
  logic             warming;
  logic             hit;

  assign warming = (fill_q != FillW'(WINDOW_LEN));

  // ties keep the earlier axis, zero peak keeps the previous axis
  always_comb begin
    peak      = '0;
    pick_axis = axis_q;
    if (dev_i[0] > peak) begin
      peak      = dev_i[0];
      pick_axis = AXIS_X;
    end
    if (dev_i[1] > peak) begin
      peak      = dev_i[1];
      pick_axis = AXIS_Y;
    end
    if (dev_i[2] > peak) begin
      peak      = dev_i[2];
      pick_axis = AXIS_Z;
    end
  end

  assign hit = !warming && (peak > threshold_i);

  assign ctl_o.warming = warming;
  assign ctl_o.shift   = step_i && !hit;
  assign ctl_o.clear   = step_i && hit;

  always_comb begin
    fill_d = fill_q;
    axis_d = axis_q;
    if (step_i) begin
      if (warming) begin
        fill_d = fill_q + FillW'(1);
      end else begin
        axis_d = pick_axis;
        if (hit) begin
          fill_d = '0;
        end
      end
    end
  end

  always_comb begin
    res_o.warming        = warming;
    res_o.impact         = hit;
    res_o.peak_deviation = warming ? '0 : peak;
    res_o.peak_axis      = warming ? axis_q : pick_axis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      axis_q <= AXIS_NONE;
    end else begin
      fill_q <= fill_d;
      axis_q <= axis_d;
    end
  end

endmodule
